>>> src/lzic_pkg.sv
package lzic_pkg;

  localparam int unsigned WinDepth = 4096;
  localparam int unsigned WinAw    = $clog2(WinDepth);
  localparam int unsigned FillW    = WinAw + 1;
  localparam int unsigned MinMatch = 3;
  localparam int unsigned RunW     = 5;

  localparam logic [WinAw-1:0] START_POS = WinAw'(12'hFEE);

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_OUT_LEN = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT  = 1'b1;

  // commands from the controller
  typedef struct packed {
    logic take;
    logic emit_lit;
    logic first_rd;
    logic emit_cp;
  } lzic_cmd_t;

  // status back from the datapath
  typedef struct packed {
    logic to_lit;
    logic to_match;
    logic out_free;
    logic run_last;
    logic hit_end;
  } lzic_sts_t;

endpackage

>>> src/lzic_in_if.sv
interface lzic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       stream_start;

  modport source (output valid, output code_byte, output stream_start, input ready);
  modport sink   (input valid, input code_byte, input stream_start, output ready);
endinterface

>>> src/lzic_out_if.sv
interface lzic_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       run_end;
  logic       stream_done;

  modport source (output valid, output plain_byte, output run_end, output stream_done,
                  input ready);
  modport sink   (input valid, input plain_byte, input run_end, input stream_done,
                  output ready);
endinterface

>>> src/lzic_cfg_if.sv
interface lzic_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lzic_pkg::CfgIdxW-1:0]     index;
  logic [lzic_pkg::CfgDataW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/lzss_inverted_count_decoder.sv
// flow: flag and low offset bytes give no output; a literal is emitted from a state of
// its own once the output is free; a match of n bytes (3..18) does one window read, then
// one output byte per cycle while the output is free, set by the single read port of the window ram
// throughput: one compressed byte at a time, next byte taken once the last is out
// reset: control state cleared at once; window content is masked by a fill count,
// so no clearing pass is needed after reset or stream start
module lzss_inverted_count_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzic_in_if.sink     in_i,
  lzic_out_if.source  out_o,
  lzic_cfg_if.sink    cfg_i
);

  lzic_pkg::lzic_cmd_t cmd;
  lzic_pkg::lzic_sts_t sts;
  logic                in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  lzic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  lzic_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .code_byte_i    (in_i.code_byte),
    .stream_start_i (in_i.stream_start),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .plain_byte_o   (out_o.plain_byte),
    .run_end_o      (out_o.run_end),
    .stream_done_o  (out_o.stream_done)
  );

endmodule

>>> src/lzic_ctrl.sv
module lzic_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lzic_pkg::lzic_sts_t sts_i,
  output logic                in_ready_o,
  output lzic_pkg::lzic_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_CP   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.to_lit) begin
            state_d = S_LIT;
          end else if (sts_i.to_match) begin
            state_d = S_RD;
          end
        end
      end
      S_LIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_lit = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.first_rd = 1'b1;
        state_d        = S_CP;
      end
      S_CP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_cp = 1'b1;
          if (sts_i.hit_end || sts_i.run_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/lzic_dpath.sv
module lzic_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lzic_pkg::lzic_cmd_t                 cmd_i,
  output lzic_pkg::lzic_sts_t                 sts_o,
  input  logic [7:0]                          code_byte_i,
  input  logic                                stream_start_i,
  input  logic                                cfg_valid_i,
  input  logic [lzic_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lzic_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [7:0]                          plain_byte_o,
  output logic                                run_end_o,
  output logic                                stream_done_o
);

  localparam int unsigned Aw = lzic_pkg::WinAw;

  localparam logic [1:0] PH_TOKEN = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;

  logic [7:0] win_mem [lzic_pkg::WinDepth];

  logic [1:0]                      ph_q;
  logic [15:0]                     fs_q;
  logic [7:0]                      off_lo_q;
  logic [Aw-1:0]                   wp_q;
  logic [lzic_pkg::FillW-1:0]      fill_q;
  logic [31:0]                     emitted_q;
  logic                            fin_q;
  logic [31:0]                     out_len_q;
  logic                            inv_q;
  logic                            out_valid_q;
  logic [lzic_pkg::RunW-1:0]       cnt_q;
  logic [Aw-1:0]                   rd_addr_q;
  logic [7:0]                      pend_q;
  logic [7:0]                      rd_q;
  logic                            rd_ok_q;
  logic                            byp_q;
  logic [7:0]                      byp_data_q;
  logic [7:0]                      plain_q;
  logic                            run_end_q;
  logic                            done_q;

  logic [7:0]                      b;
  logic [1:0]                      ph_c, ph_n, ph_eff;
  logic [15:0]                     fs_c, fs_sh, fs_n;
  logic [7:0]                      off_c, off_n;
  logic                            fin_c;
  logic                            token;
  logic                            to_lit, to_match;
  logic [lzic_pkg::RunW-1:0]       run_len;
  logic [31:0]                     emitted_inc;
  logic                            hit_end;
  logic                            run_last;
  logic                            out_free;
  logic                            emit;
  logic [7:0]                      cp_data, em_data;
  logic                            wr_en, rd_en;
  logic                            rd_ok_d;

  // token decode, with stream start clearing the state first
  always_comb begin
    b        = code_byte_i ^ {8{inv_q}};
    fs_c     = stream_start_i ? '0 : fs_q;
    ph_c     = stream_start_i ? PH_TOKEN : ph_q;
    off_c    = stream_start_i ? '0 : off_lo_q;
    fin_c    = stream_start_i ? 1'b0 : fin_q;
    fs_sh    = fs_c >> 1;
    fs_n     = fs_c;
    ph_n     = ph_c;
    ph_eff   = ph_c;
    off_n    = off_c;
    to_lit   = 1'b0;
    to_match = 1'b0;
    token    = (ph_c != PH_BODY) && (ph_c != PH_LEN);
    run_len  = lzic_pkg::RunW'(4'(~b[3:0])) + lzic_pkg::RunW'(lzic_pkg::MinMatch);
    if (!fin_c) begin
      if (token && !fs_sh[8]) begin
        fs_n = {8'hFF, b};
        ph_n = PH_BODY;
      end else begin
        if (token) begin
          fs_n   = fs_sh;
          ph_eff = PH_BODY;
        end
        if (ph_eff == PH_BODY) begin
          if (fs_n[0]) begin
            ph_n   = PH_TOKEN;
            to_lit = 1'b1;
          end else begin
            off_n = b;
            ph_n  = PH_LEN;
          end
        end else begin
          ph_n     = PH_TOKEN;
          to_match = 1'b1;
        end
      end
    end
  end

  assign emitted_inc = emitted_q + 32'd1;
  assign hit_end     = (emitted_inc == out_len_q);
  assign run_last    = (cnt_q == lzic_pkg::RunW'(1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = cmd_i.emit_lit || cmd_i.emit_cp;
  assign cp_data     = byp_q ? byp_data_q : (rd_ok_q ? rd_q : 8'h00);
  assign em_data     = cmd_i.emit_lit ? pend_q : cp_data;
  assign wr_en       = emit && !hit_end;
  assign rd_en       = cmd_i.first_rd || (cmd_i.emit_cp && !hit_end && !run_last);
  // entries outside the span written since stream start read as zero
  assign rd_ok_d     = {1'b0, rd_addr_q - lzic_pkg::START_POS} < fill_q;

  assign sts_o.to_lit   = to_lit;
  assign sts_o.to_match = to_match;
  assign sts_o.out_free = out_free;
  assign sts_o.run_last = run_last;
  assign sts_o.hit_end  = hit_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_TOKEN;
      fs_q        <= '0;
      off_lo_q    <= '0;
      wp_q        <= lzic_pkg::START_POS;
      fill_q      <= '0;
      emitted_q   <= '0;
      fin_q       <= 1'b0;
      out_len_q   <= 32'd1;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      rd_addr_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          lzic_pkg::CFG_OUT_LEN: out_len_q <= cfg_data_i;
          lzic_pkg::CFG_INVERT:  inv_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        fs_q     <= fs_n;
        ph_q     <= ph_n;
        off_lo_q <= off_n;
        if (stream_start_i) begin
          wp_q      <= lzic_pkg::START_POS;
          fill_q    <= '0;
          emitted_q <= '0;
          fin_q     <= 1'b0;
        end
        if (to_match) begin
          rd_addr_q <= {b[7:4], off_c};
          cnt_q     <= run_len;
        end
      end
      if (emit) begin
        emitted_q <= emitted_inc;
        if (hit_end) begin
          fin_q <= 1'b1;
        end else begin
          wp_q <= wp_q + Aw'(1);
          if (fill_q != lzic_pkg::FillW'(lzic_pkg::WinDepth)) begin
            fill_q <= fill_q + lzic_pkg::FillW'(1);
          end
        end
      end
      if (cmd_i.emit_cp) begin
        cnt_q <= cnt_q - lzic_pkg::RunW'(1);
      end
      if (rd_en) begin
        rd_addr_q <= rd_addr_q + Aw'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[wp_q] <= em_data;
    end
    if (rd_en) begin
      rd_q <= win_mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pend_q <= b;
    end
    if (rd_en) begin
      rd_ok_q    <= rd_ok_d;
      byp_q      <= cmd_i.emit_cp && (rd_addr_q == wp_q);
      byp_data_q <= em_data;
    end
    if (emit) begin
      plain_q   <= em_data;
      run_end_q <= cmd_i.emit_lit || run_last || hit_end;
      done_q    <= hit_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign plain_byte_o  = plain_q;
  assign run_end_o     = run_end_q;
  assign stream_done_o = done_q;

endmodule

>>> test/tb_lzss_inverted_count_decoder.sv
module tb_lzss_inverted_count_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned ItemTarget = 230;

  typedef enum logic [1:0] {
    TAKE_FLAG,
    TAKE_BODY,
    TAKE_COUNT
  } take_e;

  typedef struct packed {
    logic [7:0] plain;
    logic       run_end;
    logic       done;
  } plain_t;

  class decode_sb;
    logic [7:0]                 window [lzic_pkg::WinDepth];
    logic [lzic_pkg::WinAw-1:0] wpos;
    logic [15:0]                flags;
    take_e                      phase;
    logic [7:0]                 off_low;
    logic [31:0]                emitted;
    logic [31:0]                out_len;
    bit                         ended;
    bit                         invert;
    plain_t                     pending[$];
    int unsigned                mismatches;
    int unsigned                checked;
    int unsigned                items_used;
    int unsigned                literals;
    int unsigned                copies;
    int unsigned                streams_ended;

    function new();
      out_len = 32'd1;
      invert = 1'b0;
      mismatches = 0;
      checked = 0;
      items_used = 0;
      literals = 0;
      copies = 0;
      streams_ended = 0;
      restart();
    endfunction

    function void restart();
      foreach (window[i]) window[i] = 8'h00;
      wpos = lzic_pkg::START_POS;
      flags = 16'h0000;
      phase = TAKE_FLAG;
      off_low = 8'h00;
      emitted = 32'd0;
      ended = 1'b0;
    endfunction

    function void write_reg(logic [lzic_pkg::CfgIdxW-1:0] idx,
                            logic [lzic_pkg::CfgDataW-1:0] data);
      if (idx == lzic_pkg::CFG_OUT_LEN) out_len = data;
      else if (idx == lzic_pkg::CFG_INVERT) invert = data[0];
    endfunction

    // returns 1 when the byte completes the stream
    function bit put(logic [7:0] d);
      plain_t e;
      emitted = emitted + 32'd1;
      e.plain = d;
      e.run_end = 1'b0;
      e.done = (emitted == out_len);
      pending.push_back(e);
      if (e.done) begin
        ended = 1'b1;
        streams_ended++;
        return 1'b1;
      end
      window[wpos] = d;
      wpos = wpos + 1'b1;
      return 1'b0;
    endfunction

    function void note_code(logic [7:0] raw, logic start);
      logic [7:0]                 b;
      logic [lzic_pkg::WinAw-1:0] src;
      logic [3:0]                 cnt;
      int unsigned                run;
      int unsigned                first;
      plain_t                     e;
      items_used++;
      if (start) restart();
      if (ended) return;
      b = invert ? ~raw : raw;
      first = pending.size();
      if (phase != TAKE_BODY && phase != TAKE_COUNT) begin
        flags = flags >> 1;
        if (!flags[8]) begin
          flags = {8'hFF, b};
          phase = TAKE_BODY;
          return;
        end
        phase = TAKE_BODY;
      end
      if (phase == TAKE_BODY) begin
        if (flags[0]) begin
          phase = TAKE_FLAG;
          literals++;
          void'(put(b));
        end else begin
          off_low = b;
          phase = TAKE_COUNT;
          return;
        end
      end else begin
        src = {b[7:4], off_low};
        cnt = ~b[3:0];
        run = cnt + lzic_pkg::MinMatch;
        phase = TAKE_FLAG;
        copies++;
        for (int unsigned i = 0; i < run; i++) begin
          if (put(window[src])) break;
          src = src + 1'b1;
        end
      end
      if (pending.size() > first) begin
        e = pending.pop_back();
        e.run_end = 1'b1;
        pending.push_back(e);
      end
    endfunction

    function void check_plain(logic [7:0] plain, logic run_end, logic done);
      plain_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %02h end %0b done %0b", plain, run_end, done);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.plain !== plain || want.run_end !== run_end || want.done !== done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on output %0d: expected %02h end %0b done %0b, got %02h %0b %0b",
                   checked, want.plain, want.run_end, want.done, plain, run_end, done);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   gaps_on = 1'b1;
  int unsigned cycles = 0;
  decode_sb sb = new();

  lzic_in_if  in_if ();
  lzic_out_if out_if ();
  lzic_cfg_if cfg_if ();

  lzss_inverted_count_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= !(gaps_on && $urandom_range(99) < 13);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d outputs outstanding", cycles, sb.pending.size());
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_plain(out_if.plain_byte, out_if.run_end, out_if.stream_done);
  end

  // value is the byte as decoded; the line carries it complemented when inversion is on
  task automatic send_code(logic [7:0] value, logic start);
    logic [7:0] raw;
    raw = value ^ {8{sb.invert}};
    while (gaps_on && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.code_byte <= raw;
    in_if.stream_start <= start;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_code(raw, start);
    @(negedge clk_i);
  endtask

  task automatic settle(int unsigned extra);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [lzic_pkg::CfgIdxW-1:0] idx,
                           logic [lzic_pkg::CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // flag groups with random tokens and the odd restart, copies mostly aimed at recent history
  task automatic random_stream(bit fresh, int unsigned budget);
    logic [7:0]                 flag;
    logic [lzic_pkg::WinAw-1:0] off;
    int unsigned                used;
    int unsigned                k;
    bit                         start;
    used = 0;
    start = fresh || sb.ended;
    while (!sb.ended && used < budget || start) begin
      flag = 8'($urandom);
      send_code(flag, start);
      start = 1'b0;
      used++;
      for (k = 0; k < 8 && !sb.ended; k++) begin
        if ($urandom_range(99) < 3) begin
          send_code(8'($urandom), 1'b1);
          used++;
        end
        if (flag[k]) begin
          send_code(8'($urandom), 1'b0);
          used++;
        end else begin
          off = ($urandom_range(9) < 8)
                  ? sb.wpos - lzic_pkg::WinAw'($urandom_range(1, 40))
                  : lzic_pkg::WinAw'($urandom);
          send_code(off[7:0], 1'b0);
          send_code({off[11:8], 4'($urandom)}, 1'b0);
          used += 2;
        end
      end
    end
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned pick;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.code_byte = 8'h00;
    in_if.stream_start = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lzic_pkg::CFG_OUT_LEN;
    cfg_if.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero length, so the stream never ends
    write_reg(lzic_pkg::CFG_OUT_LEN, 32'd0);
    write_reg(lzic_pkg::CFG_INVERT, 32'd0);
    send_code(8'h05, 1'b1);
    send_code(8'hFF, 1'b0);
    send_code(8'hEE, 1'b0);
    send_code(8'hF0, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h0F, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h85, 1'b0);

    // inversion switched on mid stream
    settle(24);
    write_reg(lzic_pkg::CFG_INVERT, 32'd1);
    send_code(8'hF0, 1'b0);
    send_code(8'hF7, 1'b0);
    send_code(8'h12, 1'b0);
    send_code(8'h3A, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h5A, 1'b0);

    // stream ends inside a copy, then trailing bytes are dropped
    settle(24);
    write_reg(lzic_pkg::CFG_OUT_LEN, 32'd4);
    write_reg(lzic_pkg::CFG_INVERT, 32'd0);
    send_code(8'h00, 1'b1);
    send_code(8'hEE, 1'b0);
    send_code(8'hF0, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);

    settle(24);
    write_reg(lzic_pkg::CFG_OUT_LEN, 32'hFFFF_FFFF);
    send_code(8'hFF, 1'b1);
    send_code(8'h80, 1'b0);
    send_code(8'h7F, 1'b0);

    settle(24);
    write_reg(lzic_pkg::CFG_OUT_LEN, 32'd1);
    send_code(8'h01, 1'b1);
    send_code(8'h33, 1'b0);
    send_code(8'hC4, 1'b0);

    phase_no = 0;
    while (sb.items_used < ItemTarget) begin
      settle(24);
      gaps_on = !(phase_no >= 4 && phase_no < 7);
      pick = $urandom_range(99);
      if (pick < 60) write_reg(lzic_pkg::CFG_OUT_LEN, 32'($urandom_range(1, 150)));
      else if (pick < 70) write_reg(lzic_pkg::CFG_OUT_LEN, 32'hFFFF_FFFF);
      else if (pick < 75) write_reg(lzic_pkg::CFG_OUT_LEN, 32'd1);
      else if (pick < 80) write_reg(lzic_pkg::CFG_OUT_LEN, 32'($urandom));
      if ($urandom_range(1) == 1) write_reg(lzic_pkg::CFG_INVERT, 32'($urandom));
      random_stream($urandom_range(99) < 85, $urandom_range(8, 40));
      repeat ($urandom_range(0, 3)) send_code(8'($urandom), 1'b0);
      // noise with the odd restart
      if ($urandom_range(99) < 15)
        repeat (6) send_code(8'($urandom), $urandom_range(99) < 20);
      phase_no++;
    end

    gaps_on = 1'b1;
    settle(40);
    $display("sent %0d input bytes: %0d literals, %0d copies, %0d streams run to length",
             sb.items_used, sb.literals, sb.copies, sb.streams_ended);
    $display("%0d output bytes checked over %0d phases, %0d mismatches, %0d outstanding",
             sb.checked, phase_no, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/lzic_pkg.sv
src/lzic_in_if.sv
src/lzic_out_if.sv
src/lzic_cfg_if.sv
src/lzic_ctrl.sv
src/lzic_dpath.sv
src/lzss_inverted_count_decoder.sv
test/tb_lzss_inverted_count_decoder.sv
